// ----- design/mos6502_subset_executor_assert.svh -----
// assertion macros for the 6502 subset executor
`ifndef MOS6502_SUBSET_EXECUTOR_ASSERT_SVH
`define MOS6502_SUBSET_EXECUTOR_ASSERT_SVH

// implication checked every cycle outside reset
`define M65_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define M65_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/m65_pkg.sv -----
// ----------------------------------------------------------------------------
// m65_pkg
// shared types, codes and decode tables for the 6502 subset executor
// ----------------------------------------------------------------------------
`default_nettype none

package m65_pkg;

  localparam int unsigned MemDepth = 65536;
  localparam int unsigned MemAw    = $clog2(MemDepth);

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_UNIMPL  = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EXEC  = 1'b1;

  // addressing class of a decoded opcode
  typedef enum logic [3:0] {
    AM_IMM, AM_ZP, AM_ZPX, AM_ABS, AM_ABSX, AM_ABSY, AM_IMPL, AM_REL,
    AM_JMP, AM_BAD, AM_UNIMPL
  } amode_t;

  // what happens with the operand
  typedef enum logic [3:0] {
    K_LOGIC, K_LDA, K_CMPA, K_CMPX, K_CMPY, K_DEC, K_INX, K_INY, K_DEX, K_DEY,
    K_BR, K_JMP, K_FLAG, K_NOP, K_NONE
  } kind_t;

  typedef struct packed {
    amode_t     am;
    kind_t      kind;
    logic [2:0] base_cyc;
  } dec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_OPC, S_DEC, S_OP1, S_OP2, S_ADDR, S_RD, S_EXEC, S_WB, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic mem_wr_item;
    logic limit_hit;
    logic rd_pc;       // read memory at pc, pc increments
    logic lat_opc;
    logic lat_op1;
    logic lat_op2;
    logic form_addr;
    logic rd_ea;
    logic exec;
    logic wr_dec;
    logic out_load;
  } m65_cmd_t;

  typedef struct packed {
    logic   limit_ok;
    amode_t am;
    kind_t  kind;
  } m65_sts_t;

  function automatic logic is_bad(input logic [7:0] op);
    logic r;
    r = 1'b0;
    case (op)
      8'h02, 8'h03, 8'h04, 8'h12, 8'h13, 8'h14, 8'h1A, 8'h1B, 8'h1C, 8'h1F,
      8'h2B, 8'h2F, 8'h32, 8'h33, 8'h34, 8'h3A, 8'h3B, 8'h3C, 8'h3F, 8'h42,
      8'h43, 8'h44, 8'h4B, 8'h4F, 8'h52, 8'h53, 8'h54, 8'h5A, 8'h5B, 8'h5C,
      8'h5F, 8'h62, 8'h63, 8'h64, 8'h67, 8'h6B, 8'h6F, 8'h72, 8'h73, 8'h74,
      8'h77, 8'h7A, 8'h7B, 8'h7C, 8'h7F, 8'h80, 8'h82, 8'h83, 8'h89, 8'h8B,
      8'h8F, 8'h92, 8'h93, 8'h97, 8'h9B, 8'h9C, 8'h9E, 8'h9F, 8'hA3, 8'hA7,
      8'hAB, 8'hAF, 8'hB2, 8'hB3, 8'hB7, 8'hBB, 8'hBF, 8'hC2, 8'hC3, 8'hC7,
      8'hCB, 8'hCF, 8'hD2, 8'hD3, 8'hD4, 8'hD7, 8'hDA, 8'hDB, 8'hDC, 8'hDF,
      8'hE7, 8'hEB, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF7, 8'hFF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d = '{am: AM_UNIMPL, kind: K_NONE, base_cyc: 3'd0};
    unique case (op)
      8'h09, 8'h29, 8'h49: d = '{AM_IMM,  K_LOGIC, 3'd2};
      8'h05, 8'h25, 8'h45: d = '{AM_ZP,   K_LOGIC, 3'd3};
      8'h15, 8'h35, 8'h55: d = '{AM_ZPX,  K_LOGIC, 3'd4};
      8'h0D, 8'h2D, 8'h4D: d = '{AM_ABS,  K_LOGIC, 3'd4};
      8'h1D, 8'h3D, 8'h5D: d = '{AM_ABSX, K_LOGIC, 3'd4};
      8'h19, 8'h39, 8'h59: d = '{AM_ABSY, K_LOGIC, 3'd4};
      8'hA9: d = '{AM_IMM, K_LDA, 3'd2};
      8'hC9: d = '{AM_IMM, K_CMPA, 3'd2};
      8'hC5: d = '{AM_ZP,  K_CMPA, 3'd3};
      8'hD5: d = '{AM_ZPX, K_CMPA, 3'd4};
      8'hE0: d = '{AM_IMM, K_CMPX, 3'd2};
      8'hE4: d = '{AM_ZP,  K_CMPX, 3'd3};
      8'hEC: d = '{AM_ABS, K_CMPX, 3'd4};
      8'hC0: d = '{AM_IMM, K_CMPY, 3'd2};
      8'hC4: d = '{AM_ZP,  K_CMPY, 3'd3};
      8'hCC: d = '{AM_ABS, K_CMPY, 3'd4};
      8'hC6: d = '{AM_ZP,  K_DEC, 3'd5};
      8'hD6: d = '{AM_ZPX, K_DEC, 3'd6};
      8'hCE: d = '{AM_ABS, K_DEC, 3'd6};
      8'hE8: d = '{AM_IMPL, K_INX, 3'd2};
      8'hC8: d = '{AM_IMPL, K_INY, 3'd2};
      8'hCA: d = '{AM_IMPL, K_DEX, 3'd2};
      8'h88: d = '{AM_IMPL, K_DEY, 3'd2};
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0:
        d = '{AM_REL, K_BR, 3'd2};
      8'h4C: d = '{AM_JMP, K_JMP, 3'd3};
      8'h18, 8'h38, 8'h58, 8'h78, 8'hB8: d = '{AM_IMPL, K_FLAG, 3'd2};
      8'hEA: d = '{AM_IMPL, K_NOP, 3'd2};
      default: begin
        if (is_bad(op)) d = '{AM_BAD, K_NONE, 3'd2};
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- design/m65_if.sv -----
// ----------------------------------------------------------------------------
// m65_in_if / m65_out_if
// valid/ready channels of the executor
// ----------------------------------------------------------------------------
`default_nettype none

interface m65_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] address;
  logic [7:0]  data;
  logic [31:0] cycle_limit;
  modport source (output valid, operation, address, data, cycle_limit, input ready);
  modport sink (input valid, operation, address, data, cycle_limit, output ready);
endinterface

interface m65_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  opcode_seen;
  logic [15:0] prog_counter;
  logic [7:0]  accum;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  status_flags;
  logic [31:0] cycle_total;
  modport source (output valid, status, opcode_seen, prog_counter, accum, index_x,
                  index_y, status_flags, cycle_total, input ready);
  modport sink (input valid, status, opcode_seen, prog_counter, accum, index_x,
                index_y, status_flags, cycle_total, output ready);
endinterface

`default_nettype wire

// ----- design/m65_ctrl.sv -----
// ----------------------------------------------------------------------------
// m65_ctrl
// sequencer: one state per memory access of an instruction
// ----------------------------------------------------------------------------
`default_nettype none

module m65_ctrl
  import m65_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_op,
  input  wire logic     out_busy,
  output logic          in_ready,
  input  wire m65_sts_t sts,
  output m65_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !out_busy) begin
          if (in_op == OP_EXEC && sts.limit_ok) state_nxt = S_OPC;
          else                                  state_nxt = S_OUT;
        end
      end
      S_OPC: state_nxt = S_DEC;
      S_DEC: begin
        unique case (sts.am)
          AM_IMM, AM_ZP, AM_ZPX, AM_REL, AM_ABS, AM_ABSX, AM_ABSY, AM_JMP:
            state_nxt = S_OP1;
          default: state_nxt = S_EXEC;
        endcase
      end
      S_OP1: begin
        unique case (sts.am)
          AM_ABS, AM_ABSX, AM_ABSY, AM_JMP: state_nxt = S_OP2;
          AM_ZP, AM_ZPX:                    state_nxt = S_ADDR;
          default:                          state_nxt = S_EXEC;
        endcase
      end
      S_OP2:  state_nxt = (sts.am == AM_JMP) ? S_EXEC : S_ADDR;
      S_ADDR: state_nxt = S_RD;
      S_RD:   state_nxt = S_EXEC;
      S_EXEC: state_nxt = (sts.kind == K_DEC) ? S_WB : S_OUT;
      S_WB:   state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = !out_busy;
        cmd.take_item = in_valid && !out_busy;
        cmd.mem_wr_item = in_valid && !out_busy && in_op == OP_WRITE;
        cmd.limit_hit = in_valid && !out_busy && in_op == OP_EXEC && !sts.limit_ok;
        cmd.rd_pc     = in_valid && !out_busy && in_op == OP_EXEC && sts.limit_ok;
      end
      S_OPC: cmd.lat_opc = 1'b1;
      S_DEC: cmd.rd_pc = (sts.am != AM_IMPL && sts.am != AM_BAD && sts.am != AM_UNIMPL);
      S_OP1: begin
        cmd.lat_op1 = 1'b1;
        cmd.rd_pc = (sts.am == AM_ABS || sts.am == AM_ABSX || sts.am == AM_ABSY ||
                     sts.am == AM_JMP);
      end
      S_OP2:  cmd.lat_op2 = 1'b1;
      S_ADDR: begin
        cmd.form_addr = 1'b1;
        cmd.rd_ea     = (sts.am != AM_IMM);
      end
      S_RD:   ;
      S_EXEC: cmd.exec = 1'b1;
      S_WB:   cmd.wr_dec = 1'b1;
      S_OUT:  cmd.out_load = 1'b1;
      default: ;
    endcase
  end

  `include "mos6502_subset_executor_assert.svh"
  `M65_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE)
  `M65_ASSERT_NEXT(a_wr_to_out, cmd.mem_wr_item, state_r == S_OUT)
  `M65_ASSERT_NEXT(a_exec_done, cmd.exec && sts.kind != K_DEC, state_r == S_OUT)

endmodule

`default_nettype wire

// ----- design/m65_dpath.sv -----
// ----------------------------------------------------------------------------
// m65_dpath
// registers, memory, alu and result register of the executor
// ----------------------------------------------------------------------------
`default_nettype none

module m65_dpath
  import m65_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_data,
  input  wire logic [31:0] in_cycle_limit,
  input  wire m65_cmd_t    cmd,
  output m65_sts_t         sts,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_opcode_seen,
  output logic [15:0]      out_prog_counter,
  output logic [7:0]       out_accum,
  output logic [7:0]       out_index_x,
  output logic [7:0]       out_index_y,
  output logic [7:0]       out_status_flags,
  output logic [31:0]      out_cycle_total
);

  logic [7:0]  mem [MemDepth];
  logic [7:0]  rdata_r;
  logic [7:0]  a_r, x_r, y_r, p_r, opc_r, op1_r, op2_r;
  logic [15:0] pc_r, ea_r;
  logic [31:0] cyc_r;
  logic [1:0]  st_r;
  logic        pen_r;
  dec_t        dec;

  assign dec = decode(opc_r);
  assign sts.am   = dec.am;
  assign sts.kind = dec.kind;
  assign sts.limit_ok = cyc_r < in_cycle_limit;

  // memory: one write and one read port, read registered
  logic            mwe, mre;
  logic [MemAw-1:0] mwa, mra;
  logic [MemAw-1:0] ea_r_nxt_w;
  logic [7:0]      mwd, dec_val;
  assign dec_val = rdata_r - 8'd1;
  always_comb begin
    mwe = cmd.mem_wr_item || cmd.wr_dec;
    mre = cmd.rd_pc || cmd.rd_ea;
    mwa = cmd.wr_dec ? ea_r[MemAw-1:0] : in_address[MemAw-1:0];
    mwd = cmd.wr_dec ? dec_val : in_data;
    mra = cmd.rd_ea ? ea_r_nxt_w : pc_r[MemAw-1:0];
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    if (mre) rdata_r <= mem[mra];
  end

  // effective address
  logic [15:0] ea_nxt;
  logic [15:0] base;
  assign base = {op2_r, op1_r};
  always_comb begin
    case (dec.am)
      AM_ZP:   ea_nxt = {8'h00, op1_r};
      AM_ZPX:  ea_nxt = {8'h00, op1_r + x_r};
      AM_ABSX: ea_nxt = base + {8'h00, x_r};
      AM_ABSY: ea_nxt = base + {8'h00, y_r};
      default: ea_nxt = base;
    endcase
  end
  assign ea_r_nxt_w = ea_nxt[MemAw-1:0];

  // alu
  logic [7:0]  opnd, res, cmpr;
  logic        take;
  logic [15:0] tgt;
  logic [31:0] cyc_add;
  assign opnd = (dec.am == AM_IMM || dec.am == AM_REL) ? op1_r : rdata_r;
  always_comb begin
    case (opc_r[7:5])
      3'd0: res = a_r | opnd;
      3'd1: res = a_r & opnd;
      default: res = a_r ^ opnd;
    endcase
    case (dec.kind)
      K_CMPX:  cmpr = x_r;
      K_CMPY:  cmpr = y_r;
      default: cmpr = a_r;
    endcase
    case (opc_r[7:6])
      2'd0: take = p_r[7];
      2'd1: take = p_r[6];
      2'd2: take = p_r[0];
      default: take = p_r[1];
    endcase
    take = take == opc_r[5];
  end
  assign tgt = pc_r + {{8{op1_r[7]}}, op1_r};

  // cycles charged by the instruction, taken branch one more, two across a page
  always_comb begin
    cyc_add = {29'd0, dec.base_cyc} + {31'd0, pen_r};
    if (dec.kind == K_BR && take)
      cyc_add = (tgt[15:8] == pc_r[15:8]) ? 32'd3 : 32'd4;
  end

  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    return {v[7], p[6:2], (v == 8'd0), p[0]};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; x_r <= '0; y_r <= '0; p_r <= '0; pc_r <= '0; cyc_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.rd_pc) pc_r <= pc_r + 16'd1;
      if (cmd.take_item) begin
        st_r  <= cmd.limit_hit ? ST_LIMIT : ST_DONE;
        opc_r <= '0;
        pen_r <= 1'b0;
      end
      if (cmd.lat_opc) opc_r <= rdata_r;
      if (cmd.lat_op1) op1_r <= rdata_r;
      if (cmd.lat_op2) op2_r <= rdata_r;
      if (cmd.form_addr) begin
        ea_r  <= ea_nxt;
        pen_r <= (dec.am == AM_ABSX || dec.am == AM_ABSY) && ea_nxt[15:8] != op2_r;
      end
      if (cmd.exec) begin
        cyc_r <= cyc_r + cyc_add;
        case (dec.kind)
          K_LOGIC: begin a_r <= res; p_r <= nz(p_r, res); end
          K_LDA:   begin a_r <= opnd; p_r <= nz(p_r, opnd); end
          K_CMPA, K_CMPX, K_CMPY:
            p_r <= {nz(p_r, cmpr - opnd)} & 8'hFE | {7'd0, cmpr >= opnd};
          K_INX: begin x_r <= x_r + 8'd1; p_r <= nz(p_r, x_r + 8'd1); end
          K_INY: begin y_r <= y_r + 8'd1; p_r <= nz(p_r, y_r + 8'd1); end
          K_DEX: begin x_r <= x_r - 8'd1; p_r <= nz(p_r, x_r - 8'd1); end
          K_DEY: begin y_r <= y_r - 8'd1; p_r <= nz(p_r, y_r - 8'd1); end
          K_DEC: p_r <= nz(p_r, dec_val);
          K_BR: begin
            if (take) pc_r <= tgt;
          end
          K_JMP: pc_r <= base;
          K_FLAG: begin
            case (opc_r[7:5])
              3'd0: p_r[0] <= 1'b0;
              3'd1: p_r[0] <= 1'b1;
              3'd2: p_r[2] <= 1'b0;
              3'd3: p_r[2] <= 1'b1;
              default: p_r[6] <= 1'b0;
            endcase
          end
          default: ;
        endcase
        if (dec.am == AM_BAD) begin
          pc_r <= pc_r + 16'd1;
          st_r <= ST_ILLEGAL;
        end
        if (dec.am == AM_UNIMPL) begin
          st_r  <= ST_UNIMPL;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        out_status <= st_r; out_opcode_seen <= opc_r; out_prog_counter <= pc_r;
        out_accum <= a_r; out_index_x <= x_r; out_index_y <= y_r;
        out_status_flags <= p_r; out_cycle_total <= cyc_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `include "mos6502_subset_executor_assert.svh"
  `M65_ASSERT_NEXT(a_out_hold, out_valid && !out_ready && !cmd.out_load, out_valid)
  `M65_ASSERT_IMP(a_no_dual_wr, cmd.mem_wr_item, !cmd.wr_dec)
  `M65_ASSERT_NEXT(a_pc_step, cmd.rd_pc && !cmd.exec, pc_r == $past(pc_r) + 16'd1)

endmodule

`default_nettype wire

// ----- design/mos6502_subset_executor.sv -----
// ----------------------------------------------------------------------------
// mos6502_subset_executor
// executes one 6502 subset instruction or one memory write per word
// ----------------------------------------------------------------------------
// a write word, or an instruction word that finds the cycle count at or past its
// limit, goes straight from idle to the output state; an executed instruction
// steps through states set by the one read port of the 64k byte store: opcode,
// up to two operand bytes and one data read are fetched in turn, and dec then
// writes the byte back in its own state. a new word is taken only once the
// previous result has left the output register, and only while the controller
// is idle. memory contents are undefined until written.
`default_nettype none

module mos6502_subset_executor
  import m65_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  m65_in_if.sink   in_ch,
  m65_out_if.source out_ch
);

  m65_cmd_t cmd;
  m65_sts_t sts;
  logic     in_rdy;

  // controller holds off new words while a result waits
  m65_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .out_busy (out_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );
  assign in_ch.ready = in_rdy;

  // datapath: architectural registers, memory and result register
  m65_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_address       (in_ch.address),
    .in_data          (in_ch.data),
    .in_cycle_limit   (in_ch.cycle_limit),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_opcode_seen  (out_ch.opcode_seen),
    .out_prog_counter (out_ch.prog_counter),
    .out_accum        (out_ch.accum),
    .out_index_x      (out_ch.index_x),
    .out_index_y      (out_ch.index_y),
    .out_status_flags (out_ch.status_flags),
    .out_cycle_total  (out_ch.cycle_total)
  );

endmodule

`default_nettype wire
